[rtl/core/tcgr_pkg.sv]
package tcgr_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int GLYPH_HEIGHT    = 10;
	localparam int GLYPH_WIDTH     = 6;
	localparam int COLUMN_GAP      = 2;
	localparam int ROW_GAP         = 0;
	localparam int LINE_HEIGHT     = GLYPH_HEIGHT + ROW_GAP;
	localparam int CHAR_STEP       = GLYPH_WIDTH + COLUMN_GAP;

	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_EDGE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_EDGE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOP_EDGE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_EDGE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WORDS  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FORE_COLOR  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOR  = 3'd6;

	localparam logic [9:0]  LEFT_EDGE_RST   = 10'd0;
	localparam logic [9:0]  RIGHT_EDGE_RST  = 10'd640;
	localparam logic [9:0]  TOP_EDGE_RST    = 10'd24;
	localparam logic [9:0]  BOTTOM_EDGE_RST = 10'd456;
	localparam logic [9:0]  LINE_WORDS_RST  = 10'd320;
	localparam logic [31:0] FORE_COLOR_RST  = 32'hEB80EB80;
	localparam logic [31:0] BACK_COLOR_RST  = 32'h10801080;

	localparam logic [31:0] LEFT_MASK    = 32'hFFFF00FF;
	localparam logic [31:0] RIGHT_MASK   = 32'h0000FF00;
	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;

	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_COPY  = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] row_bits;
	} req_t;

	typedef struct packed {
		cmd_t        command;
		logic [19:0] dest_word;
		logic [19:0] source_word;
		logic [19:0] word_count;
		logic [31:0] pixel_data;
		logic        last;
	} rsp_t;

endpackage

[rtl/core/text_console_glyph_renderer.sv]
// Text console renderer for a YUYV framebuffer (two pixels per 32-bit word).
// Request channel (req_valid / req_stall / req): each request either loads one
// font row into the glyph memory or puts one character at the cursor. A request
// is taken when req_valid is high and req_stall is low; req_stall stays high
// while a character is being worked on, so one request is handled at a time.
// Result channel (rsp_valid / rsp_stall / rsp): one framebuffer command per
// result; last marks the final command of a request. A result sits in an output
// register, so the next request is taken while it still waits for the receiver.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write it only while no request is in flight.
// Sequence: a font load is done in the request cycle. A drawn character goes through
// the request cycle, one glyph memory read, then 4 * 10 word writes at one a cycle
// while the receiver does not stall, the next glyph row being read during the
// fourth word of each row. A scroll follows a character or a newline: the three
// copy and fill addresses and two counts go one after another through a single
// 10 x 11 bit multiplier.
// A stalled receiver holds the result register and pauses the word sequence.
// Reset restores all configuration registers, puts the cursor at the top left
// and leaves the glyph memory as it was; glyph rows must be loaded before use.
module text_console_glyph_renderer #(
	parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  tcgr_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output tcgr_pkg::rsp_t                      rsp
);
	import tcgr_pkg::*;

	localparam int DEPTH  = GLYPH_COUNT * 16;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_DRAW,
		S_CHECK,
		S_P_DST,
		S_P_SRC,
		S_P_CNT,
		S_COPY,
		S_P_FDST,
		S_P_FCNT,
		S_FILL
	} state_t;

	state_t      state_q;

	logic [9:0]  left_q, right_q, top_q, bottom_q, line_words_q;
	logic [31:0] fore_q, back_q;

	logic [9:0]  col_q, cursor_row_q;
	logic [10:0] rowx_q;
	logic [7:0]  code_q;
	logic        zero_q;
	logic [1:0]  ax_q;
	logic [3:0]  ay_q;
	logic [19:0] row_base_q;
	logic [9:0]  copy_h_q;
	logic [19:0] a_q, b_q, c_q;
	logic [19:0] mul_q;
	logic        out_valid_q;
	rsp_t        out_q;

	logic [7:0]  glyph_mem [DEPTH];
	logic [7:0]  rd_q;

	logic              accept_w;
	logic              code_ok_w;
	logic [11:0]       wr_idx_w, rd_idx_w;
	logic              we_w, rd_en_w;
	logic [3:0]        rd_row_w;
	logic              slot_free_w;
	logic              out_load_w;
	logic              last_row_w;
	logic              scroll_w;
	logic              copy_ok_w;
	logic [10:0]       col_adv_w;
	logic              wrap_w;
	logic [10:0]       mul_b_w;
	logic [20:0]       prod_w;
	logic [7:0]        row_bits_w;
	logic              pix_hi_w, pix_lo_w;
	logic [31:0]       word_data_w;
	rsp_t              word_w;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign accept_w    = req_valid && !req_stall;
	assign code_ok_w   = ({1'b0, req.char_code} < 9'(GLYPH_COUNT));
	assign slot_free_w = !out_valid_q || !rsp_stall;
	assign out_load_w  = slot_free_w &&
		(state_q == S_DRAW || state_q == S_COPY || state_q == S_FILL);
	assign last_row_w  = (ay_q == 4'(GLYPH_HEIGHT - 1));

	// glyph memory: font loads write, drawing reads one row ahead
	assign wr_idx_w = {req.char_code, req.glyph_row};
	assign we_w     = accept_w && (req.action == ACT_LOAD) && code_ok_w;
	assign rd_row_w = (state_q == S_FETCH) ? 4'd0 : ay_q + 4'd1;
	assign rd_idx_w = {code_q, rd_row_w};
	assign rd_en_w  = (state_q == S_FETCH) ||
		(state_q == S_DRAW && slot_free_w && ax_q == 2'd3 && !last_row_w);

	always_ff @(posedge clk) begin
		if (we_w) begin
			glyph_mem[wr_idx_w[ADDR_W-1:0]] <= req.row_bits;
		end
		if (rd_en_w) begin
			rd_q <= glyph_mem[rd_idx_w[ADDR_W-1:0]];
		end
	end

	// cursor advance and line limits
	assign col_adv_w = {1'b0, col_q} + 11'(CHAR_STEP);
	assign wrap_w    = (col_adv_w + 11'(GLYPH_WIDTH)) > {1'b0, right_q};
	assign scroll_w  = ({1'b0, rowx_q} + 12'(GLYPH_HEIGHT)) >= {2'b00, bottom_q};
	assign copy_ok_w = {1'b0, bottom_q} >= ({1'b0, top_q} + 11'(LINE_HEIGHT));

	// shared multiplier, operand chosen by the step in progress
	always_comb begin
		case (state_q)
			S_IDLE:   mul_b_w = {1'b0, cursor_row_q};
			S_CHECK:  mul_b_w = {1'b0, top_q};
			S_P_DST:  mul_b_w = {1'b0, top_q} + 11'(LINE_HEIGHT);
			S_P_SRC:  mul_b_w = {1'b0, copy_h_q};
			S_COPY:   mul_b_w = {1'b0, top_q} + {1'b0, copy_h_q};
			S_P_FDST: mul_b_w = 11'(LINE_HEIGHT);
			default:  mul_b_w = '0;
		endcase
	end

	assign prod_w = 21'(line_words_q) * 21'(mul_b_w);

	always_ff @(posedge clk) begin
		mul_q <= prod_w[19:0];
	end

	// pixel pair for word ax: bits 7-2ax and 6-2ax of the glyph row
	assign row_bits_w  = zero_q ? 8'd0 : rd_q;
	assign pix_hi_w    = row_bits_w[{~ax_q, 1'b1}];
	assign pix_lo_w    = row_bits_w[{~ax_q, 1'b0}];
	assign word_data_w = ((pix_hi_w ? fore_q : back_q) & LEFT_MASK) |
		((pix_lo_w ? fore_q : back_q) & RIGHT_MASK);

	always_comb begin
		word_w.command     = CMD_WRITE;
		word_w.dest_word   = row_base_q + 20'(ax_q);
		word_w.source_word = '0;
		word_w.word_count  = 20'd1;
		word_w.pixel_data  = word_data_w;
		word_w.last        = last_row_w && (ax_q == 2'd3) && !scroll_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= LEFT_EDGE_RST;
			right_q      <= RIGHT_EDGE_RST;
			top_q        <= TOP_EDGE_RST;
			bottom_q     <= BOTTOM_EDGE_RST;
			line_words_q <= LINE_WORDS_RST;
			fore_q       <= FORE_COLOR_RST;
			back_q       <= BACK_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEFT_EDGE:   left_q       <= cfg_data[9:0];
				CFG_RIGHT_EDGE:  right_q      <= cfg_data[9:0];
				CFG_TOP_EDGE:    top_q        <= cfg_data[9:0];
				CFG_BOTTOM_EDGE: bottom_q     <= cfg_data[9:0];
				CFG_LINE_WORDS:  line_words_q <= cfg_data[9:0];
				CFG_FORE_COLOR:  fore_q       <= cfg_data;
				CFG_BACK_COLOR:  back_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			col_q        <= LEFT_EDGE_RST;
			cursor_row_q <= TOP_EDGE_RST;
			rowx_q       <= '0;
			code_q       <= '0;
			zero_q       <= 1'b0;
			ax_q         <= '0;
			ay_q         <= '0;
			row_base_q   <= '0;
			copy_h_q     <= '0;
			a_q          <= '0;
			b_q          <= '0;
			c_q          <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept_w && req.action == ACT_PUT) begin
						code_q <= req.char_code;
						zero_q <= !code_ok_w;
						if (req.char_code == NEWLINE_CODE) begin
							rowx_q  <= {1'b0, cursor_row_q} + 11'(LINE_HEIGHT);
							col_q   <= left_q;
							state_q <= S_CHECK;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					row_base_q <= mul_q + 20'(col_q[9:1]);
					ax_q       <= '0;
					ay_q       <= '0;
					if (wrap_w) begin
						rowx_q <= {1'b0, cursor_row_q} + 11'(LINE_HEIGHT);
						col_q  <= left_q;
					end else begin
						rowx_q <= {1'b0, cursor_row_q};
						col_q  <= col_adv_w[9:0];
					end
					state_q <= S_DRAW;
				end
				S_DRAW: begin
					if (slot_free_w) begin
						out_q       <= word_w;
						ax_q        <= ax_q + 2'd1;
						if (ax_q == 2'd3) begin
							row_base_q <= row_base_q + 20'(line_words_q);
							ay_q       <= ay_q + 4'd1;
							if (last_row_w) begin
								if (scroll_w) begin
									state_q <= S_CHECK;
								end else begin
									cursor_row_q <= rowx_q[9:0];
									state_q      <= S_IDLE;
								end
							end
						end
					end
				end
				S_CHECK: begin
					if (scroll_w) begin
						if (copy_ok_w) begin
							copy_h_q <= 10'(bottom_q - top_q - 10'(LINE_HEIGHT));
						end else begin
							copy_h_q <= '0;
						end
						if (rowx_q >= 11'(LINE_HEIGHT)) begin
							cursor_row_q <= 10'(rowx_q - 11'(LINE_HEIGHT));
						end else begin
							cursor_row_q <= '0;
						end
						state_q <= S_P_DST;
					end else begin
						cursor_row_q <= rowx_q[9:0];
						state_q      <= S_IDLE;
					end
				end
				S_P_DST: begin
					a_q     <= mul_q;
					state_q <= S_P_SRC;
				end
				S_P_SRC: begin
					b_q     <= mul_q;
					state_q <= S_P_CNT;
				end
				S_P_CNT: begin
					c_q     <= mul_q;
					state_q <= S_COPY;
				end
				S_COPY: begin
					if (slot_free_w) begin
						out_q.command     <= CMD_COPY;
						out_q.dest_word   <= a_q;
						out_q.source_word <= b_q;
						out_q.word_count  <= c_q;
						out_q.pixel_data  <= '0;
						out_q.last        <= 1'b0;
						state_q           <= S_P_FDST;
					end
				end
				S_P_FDST: begin
					a_q     <= mul_q;
					state_q <= S_P_FCNT;
				end
				S_P_FCNT: begin
					c_q     <= mul_q;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (slot_free_w) begin
						out_q.command     <= CMD_FILL;
						out_q.dest_word   <= a_q;
						out_q.source_word <= '0;
						out_q.word_count  <= c_q;
						out_q.pixel_data  <= back_q;
						out_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.command == CMD_WRITE |->
			rsp.word_count == 20'd1 && rsp.source_word == 20'd0)
		else $error("write command with bad count or source");

	a_copy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.command == CMD_COPY |->
			rsp.pixel_data == 32'd0 && !rsp.last)
		else $error("copy command carries data or ends the request");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.action == ACT_LOAD |=> state_q == S_IDLE)
		else $error("font load left the sequencer busy");

	a_put_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.action == ACT_PUT |=> state_q != S_IDLE)
		else $error("character request was dropped");

	a_draw_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAW |-> {1'b0, ay_q} < 5'(GLYPH_HEIGHT))
		else $error("glyph row counter ran past the glyph height");

endmodule
